[rtl/core/cau_pkg.sv]
// Package for the complex arithmetic unit: operation and status codes,
// and the control group that travels down the pipeline. No dependencies.
package cau_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_DIV = 2'd2;
  localparam logic [1:0] OP_MAG = 2'd3;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_DZ  = 2'd1;
  localparam logic [1:0] STAT_SAT = 2'd2;

  // Control that rides alongside each item through the cell chain
  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic       sat;     // add/multiply word already saturated
    logic       dz;      // divisor is zero
    logic       neg_re;  // sign of real quotient
    logic       neg_im;  // sign of imaginary quotient
    logic       ovf_re;  // real quotient beyond word range
    logic       ovf_im;  // imaginary quotient beyond word range
  } cau_ctl_t;

endpackage

[rtl/core/cau_channel_if.sv]
// Valid/ready channels for the complex arithmetic unit: request and response.
// Depends on nothing; payload width follows the word width parameter.
interface cau_req_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic signed [W-1:0] a_re;
  logic signed [W-1:0] a_im;
  logic signed [W-1:0] b_re;
  logic signed [W-1:0] b_im;

  modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] y_re;
  logic signed [W-1:0] y_im;
  logic [1:0]          status;

  modport source (output valid, y_re, y_im, status, input ready);
  modport sink   (input valid, y_re, y_im, status, output ready);
endinterface

[rtl/core/cau_cell.sv]
// One cell of the divide / square-root chain: one quotient bit for each part
// and one root bit per cycle while adv is high. Uses cau_pkg for the control group.
module cau_cell #(
  parameter int W   = 16,
  parameter int RW  = 33,
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  cau_pkg::cau_ctl_t     ctl_i,
  input  logic [2*W-1:0]        den_i,
  input  logic [W-1:0]          nlo_re_i,
  input  logic [W-1:0]          nlo_im_i,
  input  logic [RW-1:0]         rem_re_i,
  input  logic [RW-1:0]         rem_im_i,
  input  logic [W-1:0]          q_re_i,
  input  logic [W-1:0]          q_im_i,
  input  logic [W+2:0]          srem_i,
  input  logic [W-1:0]          root_i,
  input  logic [W-1:0]          pass_re_i,
  input  logic [W-1:0]          pass_im_i,
  output cau_pkg::cau_ctl_t     ctl_o,
  output logic [2*W-1:0]        den_o,
  output logic [W-1:0]          nlo_re_o,
  output logic [W-1:0]          nlo_im_o,
  output logic [RW-1:0]         rem_re_o,
  output logic [RW-1:0]         rem_im_o,
  output logic [W-1:0]          q_re_o,
  output logic [W-1:0]          q_im_o,
  output logic [W+2:0]          srem_o,
  output logic [W-1:0]          root_o,
  output logic [W-1:0]          pass_re_o,
  output logic [W-1:0]          pass_im_o
);

  localparam int SQW = W + 3;

  logic [RW-1:0]  r2_re, r2_im, dext;
  logic           ge_re, ge_im, ge_sq;
  logic [SQW-1:0] rem2, trial;

  // Restoring divide step on each part: shift in one numerator bit
  always_comb begin
    dext  = RW'(den_i);
    r2_re = {rem_re_i[RW-2:0], nlo_re_i[W-1-IDX]};
    r2_im = {rem_im_i[RW-2:0], nlo_im_i[W-1-IDX]};
    ge_re = (r2_re >= dext);
    ge_im = (r2_im >= dext);
  end

  // Digit-by-digit square root step: bring down two radicand bits
  always_comb begin
    rem2  = {srem_i[SQW-3:0], den_i[2*W-1-2*IDX -: 2]};
    trial = SQW'({root_i, 2'b01});
    ge_sq = (rem2 >= trial);
  end

  // Control advances with the chain; only valid needs reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else if (adv) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_o     <= den_i;
      nlo_re_o  <= nlo_re_i;
      nlo_im_o  <= nlo_im_i;
      rem_re_o  <= ge_re ? (r2_re - dext) : r2_re;
      rem_im_o  <= ge_im ? (r2_im - dext) : r2_im;
      q_re_o    <= {q_re_i[W-2:0], ge_re};
      q_im_o    <= {q_im_i[W-2:0], ge_im};
      srem_o    <= ge_sq ? (rem2 - trial) : rem2;
      root_o    <= {root_i[W-2:0], ge_sq};
      pass_re_o <= pass_re_i;
      pass_im_o <= pass_im_i;
    end
  end

endmodule

[rtl/core/complex_arith_unit.sv]
// Complex add, multiply, divide and magnitude on signed fixed-point words.
// Items pass stages 0, 1 and 2, a chain of WORD_WIDTH divide/root cells (one
// bit per cell) and the output register. One item per cycle while the output
// is not stalled; an input skid register takes one item while the output
// register waits. Reset clears all valid flags at once.
module complex_arith_unit #(
  parameter int WORD_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input logic        clk,
  input logic        rst,
  cau_req_if.sink    req,
  cau_rsp_if.source  rsp
);

  localparam int W   = WORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;
  localparam int SW  = 2 * W + 1;
  localparam int NW  = 2 * W + F;
  localparam int R0W = W + F;
  localparam int RW  = ((R0W > PW) ? R0W : PW) + 1;
  localparam int SQW = W + 3;

  localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);
  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

  // Clamp a wide signed value to one word; top bit flags saturation
  function automatic logic [W:0] sat_word(input logic signed [SW-1:0] v);
    logic [W:0] r;
    if (v > MAXV) begin
      r = {1'b1, MAXV[W-1:0]};
    end else if (v < MINV) begin
      r = {1'b1, MINV[W-1:0]};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  logic adv;

  // ---------------- input skid register ----------------
  logic                skid_v;
  logic [1:0]          skid_op;
  logic signed [W-1:0] skid_ar, skid_ai, skid_br, skid_bi;
  logic                src_v;
  logic [1:0]          src_op;
  logic signed [W-1:0] src_ar, src_ai, src_br, src_bi, sq_x, sq_y;

  assign req.ready = !skid_v;

  always_comb begin
    src_v  = skid_v || req.valid;
    src_op = skid_v ? skid_op : req.req_type;
    src_ar = skid_v ? skid_ar : req.a_re;
    src_ai = skid_v ? skid_ai : req.a_im;
    src_br = skid_v ? skid_br : req.b_re;
    src_bi = skid_v ? skid_bi : req.b_im;
    // squares feed the divisor, or |a|^2 for magnitude
    sq_x   = (src_op == cau_pkg::OP_MAG) ? src_ar : src_br;
    sq_y   = (src_op == cau_pkg::OP_MAG) ? src_ai : src_bi;
  end

  // Hold an item in the skid register when the pipeline is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (adv) begin
      skid_v <= 1'b0;
    end else if (req.valid && !skid_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && req.valid && !skid_v) begin
      skid_op <= req.req_type;
      skid_ar <= req.a_re;
      skid_ai <= req.a_im;
      skid_br <= req.b_re;
      skid_bi <= req.b_im;
    end
  end

  // ---------------- stage 0: products ----------------
  logic                 s0_v;
  logic [1:0]           s0_op;
  logic signed [W-1:0]  s0_ar, s0_ai, s0_br, s0_bi;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, sq0, sq1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (adv) begin
      s0_v <= src_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_op <= src_op;
      s0_ar <= src_ar;
      s0_ai <= src_ai;
      s0_br <= src_br;
      s0_bi <= src_bi;
      p_rr  <= PW'(src_ar) * PW'(src_br);
      p_ii  <= PW'(src_ai) * PW'(src_bi);
      p_ri  <= PW'(src_ar) * PW'(src_bi);
      p_ir  <= PW'(src_ai) * PW'(src_br);
      sq0   <= PW'(sq_x) * PW'(sq_x);
      sq1   <= PW'(sq_y) * PW'(sq_y);
    end
  end

  // ---------------- stage 1: sums ----------------
  logic                 s1_v;
  logic [1:0]           s1_op;
  logic signed [W:0]    s1_add_re, s1_add_im;
  logic signed [SW-1:0] s1_m_re, s1_m_im, s1_d_re, s1_d_im;
  logic [PW-1:0]        s1_sq;
  logic signed [SW-1:0] sq_sum;

  assign sq_sum = SW'(sq0) + SW'(sq1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op     <= s0_op;
      s1_add_re <= (W+1)'(s0_ar) + (W+1)'(s0_br);
      s1_add_im <= (W+1)'(s0_ai) + (W+1)'(s0_bi);
      s1_m_re   <= SW'(p_rr) - SW'(p_ii);
      s1_m_im   <= SW'(p_ri) + SW'(p_ir);
      s1_d_re   <= SW'(p_rr) + SW'(p_ii);
      s1_d_im   <= SW'(p_ir) - SW'(p_ri);
      s1_sq     <= sq_sum[PW-1:0];
    end
  end

  // ---------------- stage 2: prepare the cell chain ----------------
  cau_pkg::cau_ctl_t    s2_ctl_next;
  logic [W:0]           sw_re, sw_im;
  logic signed [SW-1:0] m_sh_re, m_sh_im, abs_re, abs_im;
  logic [NW-1:0]        n_re, n_im;

  always_comb begin
    m_sh_re = s1_m_re >>> F;
    m_sh_im = s1_m_im >>> F;
    if (s1_op == cau_pkg::OP_ADD) begin
      sw_re = sat_word(SW'(s1_add_re));
      sw_im = sat_word(SW'(s1_add_im));
    end else begin
      sw_re = sat_word(m_sh_re);
      sw_im = sat_word(m_sh_im);
    end
    abs_re = s1_d_re[SW-1] ? -s1_d_re : s1_d_re;
    abs_im = s1_d_im[SW-1] ? -s1_d_im : s1_d_im;
    n_re   = {abs_re[PW-1:0], {F{1'b0}}};
    n_im   = {abs_im[PW-1:0], {F{1'b0}}};

    s2_ctl_next.valid  = s1_v;
    s2_ctl_next.op     = s1_op;
    s2_ctl_next.sat    = sw_re[W] || sw_im[W];
    s2_ctl_next.dz     = (s1_sq == '0);
    s2_ctl_next.neg_re = s1_d_re[SW-1];
    s2_ctl_next.neg_im = s1_d_im[SW-1];
    s2_ctl_next.ovf_re = RW'(n_re[NW-1:W]) >= RW'(s1_sq);
    s2_ctl_next.ovf_im = RW'(n_im[NW-1:W]) >= RW'(s1_sq);
  end

  // Chain taps: index 0 is stage 2, index W is the last cell
  cau_pkg::cau_ctl_t ctl_c   [W+1];
  logic [PW-1:0]     den_c   [W+1];
  logic [W-1:0]      nlo_re_c[W+1];
  logic [W-1:0]      nlo_im_c[W+1];
  logic [RW-1:0]     rem_re_c[W+1];
  logic [RW-1:0]     rem_im_c[W+1];
  logic [W-1:0]      q_re_c  [W+1];
  logic [W-1:0]      q_im_c  [W+1];
  logic [SQW-1:0]    srem_c  [W+1];
  logic [W-1:0]      root_c  [W+1];
  logic [W-1:0]      pass_re_c[W+1];
  logic [W-1:0]      pass_im_c[W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_c[0] <= '0;
    end else if (adv) begin
      ctl_c[0] <= s2_ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_c[0]     <= s1_sq;
      nlo_re_c[0]  <= n_re[W-1:0];
      nlo_im_c[0]  <= n_im[W-1:0];
      rem_re_c[0]  <= RW'(n_re[NW-1:W]);
      rem_im_c[0]  <= RW'(n_im[NW-1:W]);
      q_re_c[0]    <= '0;
      q_im_c[0]    <= '0;
      srem_c[0]    <= '0;
      root_c[0]    <= '0;
      pass_re_c[0] <= sw_re[W-1:0];
      pass_im_c[0] <= sw_im[W-1:0];
    end
  end

  // ---------------- cell chain ----------------
  for (genvar i = 0; i < W; i++) begin : g_cell
    cau_cell #(.W(W), .RW(RW), .IDX(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .ctl_i     (ctl_c[i]),
      .den_i     (den_c[i]),
      .nlo_re_i  (nlo_re_c[i]),
      .nlo_im_i  (nlo_im_c[i]),
      .rem_re_i  (rem_re_c[i]),
      .rem_im_i  (rem_im_c[i]),
      .q_re_i    (q_re_c[i]),
      .q_im_i    (q_im_c[i]),
      .srem_i    (srem_c[i]),
      .root_i    (root_c[i]),
      .pass_re_i (pass_re_c[i]),
      .pass_im_i (pass_im_c[i]),
      .ctl_o     (ctl_c[i+1]),
      .den_o     (den_c[i+1]),
      .nlo_re_o  (nlo_re_c[i+1]),
      .nlo_im_o  (nlo_im_c[i+1]),
      .rem_re_o  (rem_re_c[i+1]),
      .rem_im_o  (rem_im_c[i+1]),
      .q_re_o    (q_re_c[i+1]),
      .q_im_o    (q_im_c[i+1]),
      .srem_o    (srem_c[i+1]),
      .root_o    (root_c[i+1]),
      .pass_re_o (pass_re_c[i+1]),
      .pass_im_o (pass_im_c[i+1])
    );
  end

  // ---------------- finish: sign, clamp, select ----------------
  cau_pkg::cau_ctl_t ctl_l;
  logic [W-1:0]      q_re, q_im, root, mag_re, mag_im, fin_re, fin_im;
  logic              sat_re, sat_im;
  logic [1:0]        fin_st;

  always_comb begin
    ctl_l  = ctl_c[W];
    q_re   = q_re_c[W];
    q_im   = q_im_c[W];
    root   = root_c[W];
    sat_re = ctl_l.ovf_re || (ctl_l.neg_re ? (q_re > LIM_NEG) : (q_re > LIM_POS));
    sat_im = ctl_l.ovf_im || (ctl_l.neg_im ? (q_im > LIM_NEG) : (q_im > LIM_POS));
    mag_re = sat_re ? (ctl_l.neg_re ? LIM_NEG : LIM_POS) : q_re;
    mag_im = sat_im ? (ctl_l.neg_im ? LIM_NEG : LIM_POS) : q_im;
    case (ctl_l.op)
      cau_pkg::OP_ADD, cau_pkg::OP_MUL: begin
        fin_re = pass_re_c[W];
        fin_im = pass_im_c[W];
        fin_st = ctl_l.sat ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK;
      end
      cau_pkg::OP_DIV: begin
        if (ctl_l.dz) begin
          fin_re = '0;
          fin_im = '0;
          fin_st = cau_pkg::STAT_DZ;
        end else begin
          fin_re = ctl_l.neg_re ? (W'(0) - mag_re) : mag_re;
          fin_im = ctl_l.neg_im ? (W'(0) - mag_im) : mag_im;
          fin_st = (sat_re || sat_im) ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK;
        end
      end
      default: begin
        fin_re = (root > LIM_POS) ? LIM_POS : root;
        fin_im = '0;
        fin_st = (root > LIM_POS) ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK;
      end
    endcase
  end

  // ---------------- output register ----------------
  logic out_v;

  assign adv       = !out_v || rsp.ready;
  assign rsp.valid = out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= ctl_l.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.y_re   <= fin_re;
      rsp.y_im   <= fin_im;
      rsp.status <= fin_st;
    end
  end

endmodule

[rtl/core/cau_checker.sv]
// Port-level checks for complex_arith_unit, attached by bind.
// Depends on cau_pkg for status codes and on the top level's channels.
module cau_checker #(
  parameter int W = 16
) (
  input logic                clk,
  input logic                rst,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic signed [W-1:0] y_re,
  input logic signed [W-1:0] y_im,
  input logic [1:0]          status
);

  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  // Hold a stalled item unchanged
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(y_re) && $stable(y_im)
      && $stable(status))
    else $error("response changed while stalled");

  // Come out of reset empty and ready
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("not empty after reset");

  // Never show the unused status code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status != 2'd3)
    else $error("undefined status code");

  // Drive zero on divide by zero
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == cau_pkg::STAT_DZ |-> y_re == '0 && y_im == '0)
    else $error("divide by zero result not zero");

  // A saturated item carries at least one clamped part
  a_sat_clamp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == cau_pkg::STAT_SAT |->
      y_re == WMAX || y_re == WMIN || y_im == WMAX || y_im == WMIN)
    else $error("saturation flagged without clamped part");

endmodule

bind complex_arith_unit cau_checker #(.W(WORD_WIDTH)) u_cau_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .y_re      (rsp.y_re),
  .y_im      (rsp.y_im),
  .status    (rsp.status)
);
